// File: design/vlfp_pkg.sv
// ----------------------------------------------------------------------------
// vlfp_pkg
// types and constants shared by the varint length frame parser
// ----------------------------------------------------------------------------
package vlfp_pkg;

    localparam int unsigned LEN_W       = 24;
    localparam int unsigned ACC_W       = 32;
    localparam int unsigned CNT_W       = 3;
    localparam int unsigned VARINT_MAX  = 5;
    localparam logic [ACC_W-1:0] MAX_ID = 32'd255;

    typedef enum logic [2:0] {
        KIND_RAW_HDR   = 3'd0,
        KIND_PAYLOAD   = 3'd1,
        KIND_COMP_HDR  = 3'd2,
        KIND_COMP_BYTE = 3'd3,
        KIND_ERROR     = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_LEN_LONG   = 3'd1,
        ERR_BAD_LEN    = 3'd2,
        ERR_DATA_LONG  = 3'd3,
        ERR_CLAIM_BIG  = 3'd4,
        ERR_BAD_ID     = 3'd5,
        ERR_FRAME_END  = 3'd6
    } err_t;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_DLEN = 2'd1,
        PH_ID   = 2'd2,
        PH_BODY = 2'd3
    } phase_t;

    typedef enum logic [0:0] {
        CFG_MAX_FRAME_LENGTH = 1'b0,
        CFG_COMPRESSION_ON   = 1'b1
    } cfg_index_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       packet_id;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] uncompressed_length;
        logic [LEN_W-1:0] frame_length;
        logic             last;
        err_t             err_code;
    } result_t;

    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [CNT_W-1:0] cnt;
        logic             more;
        logic             too_long;
    } varint_t;

endpackage

// File: design/vlfp_in_if.sv
// ----------------------------------------------------------------------------
// vlfp_in_if
// byte request channel into the frame parser
// ----------------------------------------------------------------------------
interface vlfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_in;

    modport source (output valid, output data_in, input ready);
    modport sink   (input valid, input data_in, output ready);
endinterface

// File: design/vlfp_out_if.sv
// ----------------------------------------------------------------------------
// vlfp_out_if
// result request channel out of the frame parser
// ----------------------------------------------------------------------------
interface vlfp_out_if;
    logic                         valid;
    logic                         ready;
    vlfp_pkg::kind_t              kind;
    logic [7:0]                   packet_id;
    logic [7:0]                   data_byte;
    logic [vlfp_pkg::LEN_W-1:0]   uncompressed_length;
    logic [vlfp_pkg::LEN_W-1:0]   frame_length;
    logic                         last;
    vlfp_pkg::err_t               err_code;

    modport source (output valid, output kind, output packet_id, output data_byte,
                    output uncompressed_length, output frame_length, output last,
                    output err_code, input ready);
    modport sink   (input valid, input kind, input packet_id, input data_byte,
                    input uncompressed_length, input frame_length, input last,
                    input err_code, output ready);
endinterface

// File: design/vlfp_varint.sv
// ----------------------------------------------------------------------------
// vlfp_varint
// folds one base-128 byte into the varint accumulator
// ----------------------------------------------------------------------------
module vlfp_varint (
    input  logic [vlfp_pkg::ACC_W-1:0] acc,
    input  logic [vlfp_pkg::CNT_W-1:0] cnt,
    input  logic [7:0]                 data_in,
    output vlfp_pkg::varint_t          step
);
    import vlfp_pkg::*;

    logic [ACC_W-1:0] shifted;

    // bits past bit 31 of a fifth byte are dropped
    always_comb
    begin
        unique case (cnt)
            3'd0:    shifted = {25'b0, data_in[6:0]};
            3'd1:    shifted = {18'b0, data_in[6:0], 7'b0};
            3'd2:    shifted = {11'b0, data_in[6:0], 14'b0};
            3'd3:    shifted = {4'b0, data_in[6:0], 21'b0};
            3'd4:    shifted = {data_in[3:0], 28'b0};
            default: shifted = '0;
        endcase
    end

    assign step.acc      = acc | shifted;
    assign step.cnt      = cnt + CNT_W'(1);
    assign step.more     = data_in[7];
    assign step.too_long = data_in[7] && (cnt == CNT_W'(VARINT_MAX - 1));

endmodule

// File: design/varint_length_frame_parser_top.sv
// the result of an accepted byte is registered straight into the output register
// throughput: one byte per cycle; input stalls while a result waits on the output
// quiet varint bytes give no result; after an error every byte is taken and dropped
// reset: asynchronous, active low; parser returns to frame length, error cleared,
// max_frame_length 2097152, compression off
// ----------------------------------------------------------------------------
// varint_length_frame_parser_top
// splits a byte stream into varint length prefixed frames with optional
// compression header, emitting headers, body bytes and sticky errors
// ----------------------------------------------------------------------------
module varint_length_frame_parser_top (
    input  logic                        clk,
    input  logic                        rst_n,
    vlfp_in_if.sink                     stream,
    vlfp_out_if.source                  result,
    input  logic                        cfg_we,
    input  vlfp_pkg::cfg_index_t        cfg_index,
    input  logic [vlfp_pkg::LEN_W-1:0]  cfg_wdata
);
    import vlfp_pkg::*;

    logic [LEN_W-1:0] max_len_reg;
    logic             comp_on_reg;

    phase_t           phase_reg, phase_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic [LEN_W-1:0] held_reg, held_next;
    logic             comp_reg, comp_next;
    logic             halted_reg, halted_next;

    logic             out_valid_reg;
    result_t          out_reg;

    result_t          res;
    logic             emit;
    logic             accept;
    logic [LEN_W-1:0] left_dec;
    logic             frame_done;
    logic             over_max;
    varint_t          vi;

    vlfp_varint u_varint (
        .acc     (acc_reg),
        .cnt     (cnt_reg),
        .data_in (stream.data_in),
        .step    (vi)
    );

    assign stream.ready = !out_valid_reg || result.ready;
    assign accept       = stream.valid && stream.ready;

    assign left_dec   = (left_reg != '0) ? left_reg - LEN_W'(1) : left_reg;
    assign frame_done = (left_dec == '0);
    assign over_max   = vi.acc > {{(ACC_W-LEN_W){1'b0}}, max_len_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= LEN_W'(2097152);
            comp_on_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_FRAME_LENGTH: max_len_reg <= cfg_wdata;
                CFG_COMPRESSION_ON:   comp_on_reg <= cfg_wdata[0];
            endcase
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        left_next   = left_reg;
        held_next   = held_reg;
        comp_next   = comp_reg;
        halted_next = halted_reg;
        emit        = 1'b0;
        res         = '{kind: KIND_ERROR, err_code: ERR_NONE, default: '0};

        if (!halted_reg)
        begin
            if (phase_reg == PH_LEN)
            begin
                if (vi.more)
                begin
                    if (vi.too_long)
                    begin
                        emit         = 1'b1;
                        res.err_code = ERR_LEN_LONG;
                    end
                    else
                    begin
                        acc_next = vi.acc;
                        cnt_next = vi.cnt;
                    end
                end
                else
                begin
                    acc_next = '0;
                    cnt_next = '0;
                    if ((vi.acc == '0) || over_max)
                    begin
                        emit         = 1'b1;
                        res.err_code = ERR_BAD_LEN;
                    end
                    else
                    begin
                        left_next  = vi.acc[LEN_W-1:0];
                        held_next  = vi.acc[LEN_W-1:0];
                        comp_next  = 1'b0;
                        phase_next = comp_on_reg ? PH_DLEN : PH_ID;
                    end
                end
            end
            else
            begin
                left_next = left_dec;
                if (phase_reg == PH_BODY)
                begin
                    emit          = 1'b1;
                    res.kind      = comp_reg ? KIND_COMP_BYTE : KIND_PAYLOAD;
                    res.data_byte = stream.data_in;
                    res.last      = frame_done;
                    if (frame_done)
                        phase_next = PH_LEN;
                end
                else if (vi.more)
                begin
                    if (vi.too_long)
                    begin
                        emit         = 1'b1;
                        res.err_code = ERR_DATA_LONG;
                    end
                    else if (frame_done)
                    begin
                        emit         = 1'b1;
                        res.err_code = ERR_FRAME_END;
                    end
                    else
                    begin
                        acc_next = vi.acc;
                        cnt_next = vi.cnt;
                    end
                end
                else
                begin
                    acc_next = '0;
                    cnt_next = '0;
                    if (phase_reg == PH_DLEN)
                    begin
                        if (vi.acc == '0)
                        begin
                            if (frame_done)
                            begin
                                emit         = 1'b1;
                                res.err_code = ERR_FRAME_END;
                            end
                            else
                                phase_next = PH_ID;
                        end
                        else if (over_max)
                        begin
                            emit         = 1'b1;
                            res.err_code = ERR_CLAIM_BIG;
                        end
                        else
                        begin
                            emit                    = 1'b1;
                            comp_next               = 1'b1;
                            phase_next              = frame_done ? PH_LEN : PH_BODY;
                            res.kind                = KIND_COMP_HDR;
                            res.uncompressed_length = vi.acc[LEN_W-1:0];
                            res.frame_length        = held_reg;
                            res.last                = frame_done;
                        end
                    end
                    else if (vi.acc > MAX_ID)
                    begin
                        emit         = 1'b1;
                        res.err_code = ERR_BAD_ID;
                    end
                    else
                    begin
                        emit             = 1'b1;
                        comp_next        = 1'b0;
                        phase_next       = frame_done ? PH_LEN : PH_BODY;
                        res.kind         = KIND_RAW_HDR;
                        res.packet_id    = vi.acc[7:0];
                        res.frame_length = held_reg;
                        res.last         = frame_done;
                    end
                end
            end

            // any fault halts the parser
            if (emit && (res.kind == KIND_ERROR))
            begin
                halted_next = 1'b1;
                phase_next  = PH_LEN;
                acc_next    = '0;
                cnt_next    = '0;
                res.last    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEN;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            left_reg   <= '0;
            held_reg   <= '0;
            comp_reg   <= 1'b0;
            halted_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            left_reg   <= left_next;
            held_reg   <= held_next;
            comp_reg   <= comp_next;
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && emit)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
            out_reg <= res;
    end

    assign result.valid               = out_valid_reg;
    assign result.kind                = out_reg.kind;
    assign result.packet_id           = out_reg.packet_id;
    assign result.data_byte           = out_reg.data_byte;
    assign result.uncompressed_length = out_reg.uncompressed_length;
    assign result.frame_length        = out_reg.frame_length;
    assign result.last                = out_reg.last;
    assign result.err_code            = out_reg.err_code;

`ifndef SYNTHESIS
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("error halt cleared without reset");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (halted_reg && (!out_valid_reg || result.ready)) |=> !out_valid_reg)
        else $error("result produced after error halt");

    a_body_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (left_reg != '0))
        else $error("body phase with no bytes left in frame");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.kind == KIND_ERROR)) |-> (out_reg.last && halted_reg))
        else $error("error result without last or halt");
`endif

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// testbench for the varint length prefixed frame parser: drives byte
// requests with random gaps, back-pressures the result channel, decodes each
// accepted byte in a local model and checks every result field in order
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vlfp_pkg::*;

    typedef logic [7:0] octet_q_t[$];

    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned IDLE_GAP      = 4;
    localparam int unsigned HOLD_OFF      = 80;
    localparam int unsigned RANDOM_TARGET = 1600;
    localparam int unsigned CALM_FROM     = RANDOM_TARGET - 200;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    cfg_index_t       cfg_index;
    logic [LEN_W-1:0] cfg_wdata;

    vlfp_in_if  stream_ch();
    vlfp_out_if result_ch();

    varint_length_frame_parser_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // local copy of the parser
    logic [LEN_W-1:0] cfg_max_len  = 24'd2097152;
    logic             cfg_comp_on  = 1'b0;
    phase_t           parse_step   = PH_LEN;
    logic [31:0]      vacc         = '0;
    int unsigned      vcount       = 0;
    logic [LEN_W-1:0] frame_left   = '0;
    logic [LEN_W-1:0] frame_held   = '0;
    logic             in_packed    = 1'b0;
    logic             halted       = 1'b0;

    result_t          decoded_results[$];

    int unsigned      bytes_sent      = 0;
    int unsigned      frames_sent     = 0;
    int unsigned      results_checked = 0;
    int unsigned      mismatches      = 0;
    int unsigned      hold_off_cycles = 0;
    logic             calm            = 1'b0;
    err_t             fault_code      = ERR_NONE;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void push_result(kind_t k, logic [7:0] id, logic [7:0] d,
                                        logic [LEN_W-1:0] ulen, logic [LEN_W-1:0] flen,
                                        logic lst, err_t e);
        result_t r;
        r.kind                = k;
        r.packet_id           = id;
        r.data_byte           = d;
        r.uncompressed_length = ulen;
        r.frame_length        = flen;
        r.last                = lst;
        r.err_code            = e;
        decoded_results       = {decoded_results, r};
    endfunction

    function automatic void halt_with(err_t code);
        halted     = 1'b1;
        parse_step = PH_LEN;
        vacc       = '0;
        vcount     = 0;
        push_result(KIND_ERROR, 8'd0, 8'd0, '0, '0, 1'b1, code);
    endfunction

    function automatic void absorb_varint(logic [7:0] b);
        logic [31:0] part;
        part = {25'd0, b[6:0]};
        if (vcount < VARINT_MAX)
            vacc |= part << (7 * vcount);
        vcount++;
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        logic [31:0] value;
        if (halted)
            return;
        if (parse_step == PH_LEN)
        begin
            absorb_varint(b);
            if (b[7])
            begin
                if (vcount >= VARINT_MAX)
                    halt_with(ERR_LEN_LONG);
                return;
            end
            value  = vacc;
            vacc   = '0;
            vcount = 0;
            if (value == 0 || value > {8'd0, cfg_max_len})
            begin
                halt_with(ERR_BAD_LEN);
                return;
            end
            frame_left = value[LEN_W-1:0];
            frame_held = value[LEN_W-1:0];
            in_packed  = 1'b0;
            parse_step = cfg_comp_on ? PH_DLEN : PH_ID;
            return;
        end
        if (frame_left != 0)
            frame_left--;
        if (parse_step == PH_BODY)
        begin
            if (frame_left == 0)
                parse_step = PH_LEN;
            push_result(in_packed ? KIND_COMP_BYTE : KIND_PAYLOAD, 8'd0, b, '0, '0,
                        frame_left == 0, ERR_NONE);
            return;
        end
        absorb_varint(b);
        if (b[7])
        begin
            if (vcount >= VARINT_MAX)
                halt_with(ERR_DATA_LONG);
            else if (frame_left == 0)
                halt_with(ERR_FRAME_END);
            return;
        end
        value  = vacc;
        vacc   = '0;
        vcount = 0;
        if (parse_step == PH_DLEN)
        begin
            if (value == 0)
            begin
                if (frame_left == 0)
                    halt_with(ERR_FRAME_END);
                else
                    parse_step = PH_ID;
                return;
            end
            if (value > {8'd0, cfg_max_len})
            begin
                halt_with(ERR_CLAIM_BIG);
                return;
            end
            in_packed  = 1'b1;
            parse_step = (frame_left != 0) ? PH_BODY : PH_LEN;
            push_result(KIND_COMP_HDR, 8'd0, 8'd0, value[LEN_W-1:0], frame_held,
                        frame_left == 0, ERR_NONE);
            return;
        end
        if (value > MAX_ID)
        begin
            halt_with(ERR_BAD_ID);
            return;
        end
        in_packed  = 1'b0;
        parse_step = (frame_left != 0) ? PH_BODY : PH_LEN;
        push_result(KIND_RAW_HDR, value[7:0], 8'd0, '0, frame_held, frame_left == 0,
                    ERR_NONE);
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_result();
        result_t want;
        if (decoded_results.size() == 0)
        begin
            $error("kind mismatch: expected no result, actual %0d", result_ch.kind);
            mismatches++;
            return;
        end
        want = decoded_results[0];
        decoded_results.delete(0);
        results_checked++;
        compare_field("kind", want.kind, result_ch.kind);
        compare_field("packet_id", want.packet_id, result_ch.packet_id);
        compare_field("data_byte", want.data_byte, result_ch.data_byte);
        compare_field("uncompressed_length", want.uncompressed_length,
                      result_ch.uncompressed_length);
        compare_field("frame_length", want.frame_length, result_ch.frame_length);
        compare_field("last", want.last, result_ch.last);
        compare_field("err_code", want.err_code, result_ch.err_code);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
                check_result();
            if (cfg_we)
            begin
                if (cfg_index == CFG_MAX_FRAME_LENGTH)
                    cfg_max_len = cfg_wdata;
                else
                    cfg_comp_on = cfg_wdata[0];
            end
            if (stream_ch.valid && stream_ch.ready)
                decode_byte(stream_ch.data_in);
        end
    end

    // result side back-pressure
    initial
    begin
        int unsigned stall;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles != 0)
            begin
                stall           = hold_off_cycles;
                hold_off_cycles = 0;
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
                result_ch.ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                result_ch.ready <= 1'b1;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || cfg_we || (stream_ch.valid && stream_ch.ready) ||
                (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("watchdog: no request moved for %0d cycles", quiet);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic octet_q_t encode_varint(logic [31:0] v, int unsigned span);
        octet_q_t q;
        int unsigned n;
        logic [7:0] octet;
        n = 1;
        while (n < VARINT_MAX && (v >> (7 * n)) != 0)
            n++;
        if (span > n)
            n = span;
        for (int unsigned i = 0; i < n; i++)
        begin
            octet = ((i + 1 < n) ? 8'h80 : 8'h00) | (8'(v >> (7 * i)) & 8'h7F);
            q     = {q, octet};
        end
        return q;
    endfunction

    function automatic octet_q_t raw_body(logic [31:0] id, int unsigned body,
                                          int unsigned dspan, int unsigned ispan);
        octet_q_t tail;
        octet_q_t part;
        if (cfg_comp_on)
            tail = encode_varint(32'd0, dspan);
        part = encode_varint(id, ispan);
        tail = {tail, part};
        repeat (body) tail = {tail, 8'($urandom())};
        return tail;
    endfunction

    function automatic octet_q_t packed_body(logic [31:0] claim, int unsigned body,
                                             int unsigned cspan);
        octet_q_t tail;
        tail = encode_varint(claim, cspan);
        repeat (body) tail = {tail, 8'($urandom())};
        return tail;
    endfunction

    function automatic int unsigned random_span();
        return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
    endfunction

    function automatic octet_q_t random_tail();
        octet_q_t tail;
        int unsigned body;
        do
        begin
            body = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
            if (cfg_comp_on && $urandom_range(0, 1) == 1)
                tail = packed_body($urandom_range(1, cfg_max_len), body, random_span());
            else
                tail = raw_body($urandom_range(0, 255), body, random_span(), random_span());
        end
        while (tail.size() > cfg_max_len);
        return tail;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            stream_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        stream_ch.valid   <= 1'b1;
        stream_ch.data_in <= b;
        do
            @(posedge clk);
        while (!stream_ch.ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_bytes(input octet_q_t q);
        foreach (q[i])
            send_byte(q[i]);
    endtask

    task automatic send_frame(input octet_q_t tail, input int unsigned lspan);
        octet_q_t q;
        q = encode_varint(tail.size(), lspan);
        q = {q, tail};
        send_bytes(q);
        frames_sent++;
    endtask

    task automatic wait_idle();
        stream_ch.valid <= 1'b0;
        while (decoded_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic program_regs(input logic [LEN_W-1:0] max_len, input logic comp);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_FRAME_LENGTH;
        cfg_wdata <= max_len;
        @(negedge clk);
        cfg_index <= CFG_COMPRESSION_ON;
        cfg_wdata <= {23'd0, comp};
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic test_raw_frames();
        octet_q_t tail;
        octet_q_t frame;
        send_frame(raw_body(0, 0, 0, 0), 0);
        tail = encode_varint(32'd7, 0);
        tail = {tail, 8'h00, 8'hFF, 8'h80, 8'h7F};
        send_frame(tail, 0);
        send_frame(raw_body(255, 2, 0, 0), 0);
        send_frame(raw_body(127, 1, 0, 0), 2);
        send_frame(raw_body(5, 1, 0, 5), 5);
        // id with spare bits in the fifth byte
        tail = {8'h85, 8'h80, 8'h80, 8'h80, 8'h70, 8'hAA};
        send_frame(tail, 0);
        // frame length with spare bits in the fifth byte
        frame = {8'h82, 8'h80, 8'h80, 8'h80, 8'h70, 8'h09, 8'h33};
        send_bytes(frame);
        frames_sent++;
    endtask

    task automatic test_compressed_frames();
        octet_q_t tail;
        wait_idle();
        program_regs(24'd2097152, 1'b1);
        send_frame(raw_body(3, 2, 0, 0), 0);
        send_frame(raw_body(200, 1, 5, 0), 0);
        tail = {8'h80, 8'h80, 8'h80, 8'h80, 8'h10, 8'h04, 8'h5A};
        send_frame(tail, 0);
        send_frame(packed_body(1, 3, 0), 0);
        send_frame(packed_body(cfg_max_len, 1, 0), 0);
        // empty compressed body
        send_frame(packed_body(7, 0, 0), 0);
        send_frame(packed_body(300, 2, 5), 3);
    endtask

    task automatic test_register_extremes();
        wait_idle();
        program_regs(24'd1, 1'b0);
        send_frame(raw_body(0, 0, 0, 0), 0);
        wait_idle();
        program_regs(24'd1, 1'b1);
        send_frame(packed_body(1, 0, 0), 0);
        wait_idle();
        program_regs(24'hFFFFFF, 1'b1);
        send_frame(packed_body(24'hFFFFFF, 2, 0), 5);
        send_frame(raw_body(99, 200, 0, 0), 0);
        wait_idle();
        program_regs(24'hFFFFFF, 1'b0);
        send_frame(raw_body(200, 5, 0, 0), 0);
    endtask

    task automatic test_output_stall();
        wait_idle();
        program_regs(24'd2097152, 1'b0);
        hold_off_cycles = HOLD_OFF;
        send_frame(raw_body(17, 60, 0, 0), 0);
        send_frame(raw_body(18, 10, 0, 0), 0);
    endtask

    task automatic test_random_traffic();
        logic [LEN_W-1:0] ceiling;
        int unsigned      frames;
        while (bytes_sent < RANDOM_TARGET)
        begin
            case ($urandom_range(0, 3))
                0:       ceiling = 24'($urandom_range(4, 40));
                1:       ceiling = 24'($urandom_range(41, 1 << 20));
                2:       ceiling = 24'd2097152;
                default: ceiling = 24'hFFFFFF;
            endcase
            wait_idle();
            program_regs(ceiling, 1'($urandom_range(0, 1)));
            frames = $urandom_range(8, 24);
            repeat (frames)
            begin
                if (bytes_sent >= CALM_FROM)
                    calm = 1'b1;
                send_frame(random_tail(), random_span());
            end
        end
        calm = 1'b1;
    endtask

    task automatic test_closing_fault();
        octet_q_t    tail;
        int unsigned pick;
        pick       = $urandom_range(0, 2);
        fault_code = err_t'(3'($urandom_range(1, 6)));
        wait_idle();
        case (fault_code)
            ERR_LEN_LONG:
            begin
                program_regs(24'd100, 1'b0);
                repeat (VARINT_MAX) tail = {tail, 8'h80 | 8'($urandom_range(0, 127))};
                send_bytes(tail);
            end
            ERR_BAD_LEN:
            begin
                program_regs(24'd100, 1'($urandom_range(0, 1)));
                send_bytes(encode_varint((pick == 0) ? 0 : $urandom_range(101, 1 << 28),
                                         random_span()));
            end
            ERR_DATA_LONG:
            begin
                program_regs(24'd100, pick == 2);
                if (pick == 0)
                    tail = {8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h01, 8'h02, 8'h03, 8'h04};
                else if (pick == 1)
                    tail = {8'h80, 8'h80, 8'h80, 8'h80, 8'h80};
                else
                    tail = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h02};
                send_frame(tail, 0);
            end
            ERR_CLAIM_BIG:
            begin
                program_regs(24'd100, 1'b1);
                tail = packed_body($urandom_range(101, 1 << 24), 2, random_span());
                send_frame(tail, 0);
            end
            ERR_BAD_ID:
            begin
                program_regs(24'd100, 1'($urandom_range(0, 1)));
                send_frame(raw_body($urandom_range(256, 1 << 20), 2, 0, 0), 0);
            end
            default:
            begin
                program_regs(24'd100, pick != 0);
                if (pick == 0)
                    tail = {8'h80};
                else if (pick == 1)
                    tail = {8'h00};
                else
                    tail = {8'h00, 8'h80, 8'h80};
                send_frame(tail, 0);
            end
        endcase
        // parser is halted from here on
        repeat (8) send_byte(8'($urandom()));
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_MAX_FRAME_LENGTH;
        cfg_wdata         = '0;
        stream_ch.valid   = 1'b0;
        stream_ch.data_in = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_raw_frames();
        test_compressed_frames();
        test_register_extremes();
        test_output_stall();
        test_random_traffic();
        test_closing_fault();
        wait_idle();

        $display("covered %0d stream bytes in %0d frames, %0d results checked",
                 bytes_sent, frames_sent, results_checked);
        $display("closing fault code %0d, %0d mismatches", fault_code, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
